FILE: design/http_chunked_body_decoder_assert.svh
// assertion macros for the chunked body decoder
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcbd check failed");

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcbd check failed");

`endif

FILE: design/hcbd_pkg.sv
// shared types and constants of the chunked body decoder
// no dependencies
`default_nettype none

package hcbd_pkg;

  // width of the chunk size counter
  localparam int unsigned SizeWidth = 32;

  typedef logic [SizeWidth-1:0] size_t;

  // command codes
  localparam logic [1:0] CmdByte  = 2'd0;
  localparam logic [1:0] CmdClose = 2'd1;
  localparam logic [1:0] CmdStart = 2'd2;

  // result kinds
  localparam logic [1:0] KindIdle = 2'd0;
  localparam logic [1:0] KindByte = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;
  localparam logic [1:0] KindErr  = 2'd3;

  // error codes
  localparam logic [2:0] ErrNone          = 3'd0;
  localparam logic [2:0] ErrNoDigits      = 3'd1;
  localparam logic [2:0] ErrOverflow      = 3'd2;
  localparam logic [2:0] ErrClosedSize    = 3'd3;
  localparam logic [2:0] ErrClosedData    = 3'd4;
  localparam logic [2:0] ErrClosedTerm    = 3'd5;
  localparam logic [2:0] ErrClosedTrailer = 3'd6;

  // position within the size field
  localparam logic [1:0] PrefixNone   = 2'd0;
  localparam logic [1:0] PrefixZero   = 2'd1;
  localparam logic [1:0] PrefixX      = 2'd2;
  localparam logic [1:0] PrefixDigits = 2'd3;

  // characters
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // size line parser view of one byte
  typedef struct packed {
    logic [2:0] err;
    logic       line_end;
    logic       digit_seen;
    logic [1:0] prefix_step;
    logic       digits_stopped;
    size_t      count;
  } size_upd_t;

endpackage

`default_nettype wire

FILE: design/hcbd_stream_if.sv
// item channels of the chunked body decoder: input bytes and decoded results
// no dependencies
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic [2:0] error_code;

  modport source (output valid, result_kind, payload_byte, error_code, input ready);
  modport sink (input valid, result_kind, payload_byte, error_code, output ready);
endinterface

`default_nettype wire

FILE: design/hcbd_size_line.sv
// chunk size line parser: one byte against the current size field state
// depends on hcbd_pkg
`default_nettype none

module hcbd_size_line
  import hcbd_pkg::*;
(
  input  logic [7:0] byte_i,
  input  size_t      count_i,
  input  logic       digit_seen_i,
  input  logic [1:0] prefix_step_i,
  input  logic       digits_stopped_i,
  output size_upd_t  upd_o
);

  logic       hex_ok;
  logic [3:0] hex_val;
  logic       is_ws;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (byte_i inside {[8'h30:8'h39]}) begin
      hex_val = 4'(byte_i - 8'h30);
    end else if (byte_i inside {[8'h61:8'h66]}) begin
      hex_val = 4'(byte_i - 8'h57);
    end else if (byte_i inside {[8'h41:8'h46]}) begin
      hex_val = 4'(byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // leading whitespace: space, tab, vertical tab, form feed
  assign is_ws = byte_i inside {8'h20, 8'h09, 8'h0B, 8'h0C};

  // size field state update
  always_comb begin
    upd_o.err            = ErrNone;
    upd_o.line_end       = 1'b0;
    upd_o.digit_seen     = digit_seen_i;
    upd_o.prefix_step    = prefix_step_i;
    upd_o.digits_stopped = digits_stopped_i;
    upd_o.count          = count_i;
    if (byte_i == ChCr) begin
      // carriage return is ignored
    end else if (byte_i == ChLf) begin
      upd_o.line_end = 1'b1;
      if (!digit_seen_i) upd_o.err = ErrNoDigits;
    end else if (digits_stopped_i) begin
      // rest of line, e.g. extensions, is skipped
    end else if (prefix_step_i == PrefixNone && is_ws) begin
      // leading blank
    end else if (prefix_step_i == PrefixNone && byte_i == 8'h30) begin
      upd_o.prefix_step = PrefixZero;
      upd_o.digit_seen  = 1'b1;
    end else if (prefix_step_i == PrefixZero && (byte_i == 8'h78 || byte_i == 8'h58)) begin
      upd_o.prefix_step = PrefixX;
    end else if (!hex_ok) begin
      upd_o.digits_stopped = 1'b1;
    end else begin
      // take one hex digit, unless the top nibble is already in use
      upd_o.prefix_step = PrefixDigits;
      if (count_i[SizeWidth-1 -: 4] != 4'd0) begin
        upd_o.err = ErrOverflow;
      end else begin
        upd_o.count      = {count_i[SizeWidth-5:0], hex_val};
        upd_o.digit_seen = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/http_chunked_body_decoder.sv
// Chunked body decoder: takes one body byte, close or start command per item and
// answers each with exactly one result item (framing, payload byte, done or error).
// An item is taken every cycle; its result appears in the output register in the next
// cycle. The input stalls only while that register holds a result not yet taken.
// Depends on hcbd_pkg, hcbd_stream_if, hcbd_size_line and the assertion macro header.
`default_nettype none

`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hcbd_in_if.sink          in_i,
  hcbd_out_if.source       out_o
);

  typedef enum logic [2:0] {
    PhSize,
    PhData,
    PhTerm,
    PhTrailer,
    PhDone,
    PhError
  } phase_e;

  phase_e     phase_q, phase_d;
  size_t      count_q, count_d;
  logic       digit_seen_q, digit_seen_d;
  logic [1:0] prefix_q, prefix_d;
  logic       stopped_q, stopped_d;
  logic       nonempty_q, nonempty_d;

  logic       out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [7:0] pay_q, pay_d;
  logic [2:0] err_q, err_d;

  logic       in_acc;
  logic       out_acc;
  size_upd_t  sz;

  // handshakes: the result register frees up when it is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  hcbd_size_line u_size_line (
    .byte_i           (in_i.data_byte),
    .count_i          (count_q),
    .digit_seen_i     (digit_seen_q),
    .prefix_step_i    (prefix_q),
    .digits_stopped_i (stopped_q),
    .upd_o            (sz)
  );

  // next state and result for the item at the input
  always_comb begin
    phase_d      = phase_q;
    count_d      = count_q;
    digit_seen_d = digit_seen_q;
    prefix_d     = prefix_q;
    stopped_d    = stopped_q;
    nonempty_d   = nonempty_q;
    kind_d       = KindIdle;
    pay_d        = '0;
    err_d        = ErrNone;
    case (in_i.command)
      CmdStart: begin
        phase_d      = PhSize;
        count_d      = '0;
        digit_seen_d = 1'b0;
        prefix_d     = PrefixNone;
        stopped_d    = 1'b0;
        nonempty_d   = 1'b0;
      end
      CmdClose: begin
        case (phase_q)
          PhSize:    err_d = ErrClosedSize;
          PhData:    err_d = ErrClosedData;
          PhTerm:    err_d = ErrClosedTerm;
          PhTrailer: err_d = ErrClosedTrailer;
          default:   err_d = ErrNone;
        endcase
        if (err_d != ErrNone) begin
          kind_d  = KindErr;
          phase_d = PhError;
        end
      end
      CmdByte: begin
        case (phase_q)
          PhSize: begin
            if (sz.err != ErrNone) begin
              kind_d  = KindErr;
              err_d   = sz.err;
              phase_d = PhError;
            end else begin
              count_d      = sz.count;
              digit_seen_d = sz.digit_seen;
              prefix_d     = sz.prefix_step;
              stopped_d    = sz.digits_stopped;
              if (sz.line_end) begin
                if (sz.count == '0) begin
                  phase_d    = PhTrailer;
                  nonempty_d = 1'b0;
                end else begin
                  phase_d = PhData;
                end
              end
            end
          end
          PhData: begin
            kind_d  = KindByte;
            pay_d   = in_i.data_byte;
            count_d = count_q - size_t'(1);
            if (count_q == size_t'(1)) phase_d = PhTerm;
          end
          PhTerm: begin
            // skip up to the line feed after the chunk data
            if (in_i.data_byte == ChLf) begin
              phase_d      = PhSize;
              count_d      = '0;
              digit_seen_d = 1'b0;
              prefix_d     = PrefixNone;
              stopped_d    = 1'b0;
              nonempty_d   = 1'b0;
            end
          end
          PhTrailer: begin
            if (in_i.data_byte == ChCr) begin
              // ignored
            end else if (in_i.data_byte == ChLf) begin
              if (!nonempty_q) begin
                phase_d = PhDone;
                kind_d  = KindDone;
              end
              nonempty_d = 1'b0;
            end else begin
              nonempty_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // decoder state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      count_q      <= '0;
      digit_seen_q <= 1'b0;
      prefix_q     <= PrefixNone;
      stopped_q    <= 1'b0;
      nonempty_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        count_q      <= count_d;
        digit_seen_q <= digit_seen_d;
        prefix_q     <= prefix_d;
        stopped_q    <= stopped_d;
        nonempty_q   <= nonempty_d;
        out_valid_q  <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_d;
      pay_q  <= pay_d;
      err_q  <= err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.payload_byte = pay_q;
  assign out_o.error_code   = err_q;

  // checks
  `HCBD_ASSERT_NOW(a_data_count_nonzero, phase_q == PhData, count_q != '0)
  `HCBD_ASSERT_NOW(a_err_iff_kind, out_valid_q, (kind_q == KindErr) == (err_q != ErrNone))
  `HCBD_ASSERT_NOW(a_pay_only_bytes, out_valid_q && kind_q != KindByte, pay_q == 8'd0)
  `HCBD_ASSERT_NEXT(a_done_sticks, in_acc && kind_d == KindDone, phase_q == PhDone)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking bench for the chunked body decoder: drives framed bodies, breaks and noise
// through the input channel and checks every result item against a local predictor
// depends on hcbd_pkg, hcbd_stream_if and http_chunked_body_decoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int unsigned ItemTarget  = 1600;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldStart   = 300;
  localparam int unsigned HoldCycles  = 400;

  // command with no meaning, answered as idle
  localparam logic [1:0] CmdIgnored = 2'd3;

  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChLowX  = "x";
  localparam logic [7:0] ChUpX   = "X";
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVtab  = 8'h0B;
  localparam logic [7:0] ChFeed  = 8'h0C;
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChMinus = "-";
  localparam logic [7:0] ChSemi  = ";";

  typedef enum logic [2:0] {PhSize, PhData, PhTerm, PhTrailer, PhDone, PhError} dec_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pay;
    logic [2:0] err;
  } result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } stim_item_t;

  // predicts the decoder's answer to each accepted item and checks the results
  class chunk_body_board;
    result_t     expected_results[$];
    dec_phase_e  phase;
    size_t       left;
    bit          digit_seen;
    bit          digits_stopped;
    bit          line_nonempty;
    logic [1:0]  prefix_step;
    int unsigned fails;

    function new();
      fails = 0;
      restart_line();
    endfunction

    function void restart_line();
      phase          = PhSize;
      left           = '0;
      digit_seen     = 1'b0;
      prefix_step    = PrefixNone;
      digits_stopped = 1'b0;
      line_nonempty  = 1'b0;
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - ChZero);
      if (c >= "a" && c <= "f") return int'(c - 8'("a")) + 10;
      if (c >= "A" && c <= "F") return int'(c - 8'("A")) + 10;
      return -1;
    endfunction

    function logic [2:0] take_digit(logic [3:0] d);
      if (left[SizeWidth-1 -: 4] != 4'd0) return ErrOverflow;
      left = {left[SizeWidth-5:0], d};
      digit_seen = 1'b1;
      return ErrNone;
    endfunction

    // one byte of a size line
    function logic [2:0] size_line_byte(logic [7:0] c);
      int h;
      if (c == ChCr) return ErrNone;
      if (c == ChLf) begin
        if (!digit_seen) return ErrNoDigits;
        if (left == '0) begin
          phase = PhTrailer;
          line_nonempty = 1'b0;
        end else begin
          phase = PhData;
        end
        return ErrNone;
      end
      if (digits_stopped) return ErrNone;
      h = hex_of(c);
      if (prefix_step == PrefixNone) begin
        if (c == ChSpace || c == ChTab || c == ChVtab || c == ChFeed) return ErrNone;
        if (c == ChZero) begin
          prefix_step = PrefixZero;
          digit_seen = 1'b1;
          return ErrNone;
        end
        if (h < 0) begin
          digits_stopped = 1'b1;
          return ErrNone;
        end
        prefix_step = PrefixDigits;
        return take_digit(h[3:0]);
      end
      if (prefix_step == PrefixZero && (c == ChLowX || c == ChUpX)) begin
        prefix_step = PrefixX;
        return ErrNone;
      end
      if (h < 0) begin
        digits_stopped = 1'b1;
        return ErrNone;
      end
      prefix_step = PrefixDigits;
      return take_digit(h[3:0]);
    endfunction

    function void note_accepted(logic [1:0] cmd, logic [7:0] c);
      result_t r;
      r = '{kind: KindIdle, pay: 8'h00, err: ErrNone};
      case (cmd)
        CmdStart: restart_line();
        CmdClose: begin
          case (phase)
            PhSize:    r.err = ErrClosedSize;
            PhData:    r.err = ErrClosedData;
            PhTerm:    r.err = ErrClosedTerm;
            PhTrailer: r.err = ErrClosedTrailer;
            default:   r.err = ErrNone;
          endcase
          if (r.err != ErrNone) begin
            r.kind = KindErr;
            phase = PhError;
          end
        end
        CmdByte: begin
          case (phase)
            PhSize: begin
              r.err = size_line_byte(c);
              if (r.err != ErrNone) begin
                r.kind = KindErr;
                phase = PhError;
              end
            end
            PhData: begin
              r.kind = KindByte;
              r.pay = c;
              left = left - size_t'(1);
              if (left == '0) phase = PhTerm;
            end
            PhTerm: if (c == ChLf) restart_line();
            PhTrailer: begin
              if (c == ChLf) begin
                if (!line_nonempty) begin
                  phase = PhDone;
                  r.kind = KindDone;
                end
                line_nonempty = 1'b0;
              end else if (c != ChCr) begin
                line_nonempty = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] pay, logic [2:0] err);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %02h err %0d",
                 $time, kind, pay, err);
        fails++;
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: result_kind mismatch, expected %0d, actual %0d", $time, want.kind, kind);
        fails++;
      end
      if (pay !== want.pay) begin
        $display("%0t: payload_byte mismatch, expected %02h, actual %02h", $time, want.pay, pay);
        fails++;
      end
      if (err !== want.err) begin
        $display("%0t: error_code mismatch, expected %0d, actual %0d", $time, want.err, err);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycle_count = 0;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  chunk_body_board board;
  stim_item_t      stim_q[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // stimulus building
  function automatic void push_item(logic [1:0] cmd, logic [7:0] data);
    stim_q.push_back('{cmd: cmd, data: data});
  endfunction

  // body byte, now and then preceded by an ignored command
  function automatic void push_byte(logic [7:0] b);
    if ($urandom_range(0, 59) == 0) push_item(CmdIgnored, 8'($urandom));
    push_item(CmdByte, b);
  endfunction

  function automatic void push_crlf();
    if ($urandom_range(0, 3) != 0) push_byte(ChCr);
    push_byte(ChLf);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic void push_hex(logic [31:0] value, int unsigned ndig, bit upper);
    logic [3:0] nib;
    for (int k = int'(ndig) - 1; k >= 0; k--) begin
      nib = (k >= 8) ? 4'd0 : 4'(value >> (4 * k));
      if (nib < 4'd10) push_byte(ChZero + 8'(nib));
      else push_byte((upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10);
    end
  endfunction

  // size line: optional whitespace, optional 0x, digits, optional extension
  function automatic void add_size_line(logic [31:0] size);
    logic [7:0]  blanks[5];
    logic [31:0] v;
    int unsigned ndig;
    blanks = '{ChSpace, ChTab, ChVtab, ChFeed, ChCr};
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) push_byte(blanks[$urandom_range(0, 4)]);
    if ($urandom_range(0, 3) == 0) begin
      push_byte(ChZero);
      push_byte($urandom_range(0, 1) ? ChUpX : ChLowX);
    end
    ndig = 1;
    for (v = size >> 4; v != 0; v = v >> 4) ndig++;
    if ($urandom_range(0, 3) == 0) ndig += $urandom_range(1, 2);
    push_hex(size, ndig, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) == 0) begin
      push_byte(ChSemi);
      repeat ($urandom_range(1, 5)) push_byte(printable());
    end
    push_crlf();
  endfunction

  // one body: mostly well formed, the rest broken or noisy
  function automatic void add_random_body();
    int unsigned style;
    int unsigned first;
    int unsigned cut;
    logic [31:0] size;
    style = $urandom_range(0, 99);
    first = stim_q.size();
    if ($urandom_range(0, 9) != 0) push_item(CmdStart, 8'($urandom));
    if (style < 6) begin
      // size wider than the counter
      push_hex({4'($urandom_range(1, 15)), 28'($urandom)}, 8, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 2)) push_hex(32'($urandom_range(0, 15)), 1, 1'b0);
      push_crlf();
    end else if (style < 9) begin
      // widest size that fits, cut short by a close
      push_hex(32'hFFFF_FFFF, 8, 1'($urandom_range(0, 1)));
      push_crlf();
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      push_item(CmdClose, 8'($urandom));
    end else if (style < 17) begin
      // malformed size line
      case ($urandom_range(0, 4))
        0: begin
          push_byte(ChPlus);
          push_hex(32'($urandom_range(0, 15)), 1, 1'b0);
        end
        1: begin
          push_byte(ChMinus);
          push_hex(32'($urandom_range(0, 15)), 1, 1'b1);
        end
        2: ;
        3: begin
          push_byte(ChSemi);
          push_byte(printable());
        end
        default: begin
          push_byte(ChSpace);
          push_byte("g");
        end
      endcase
      push_crlf();
    end else begin
      // well formed chunks, random payload
      repeat ($urandom_range(0, 3)) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        add_size_line(size);
        repeat (size) push_byte(8'($urandom));
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_byte(printable());
        push_crlf();
      end
      // last chunk, with 0x and no digits now and then
      if ($urandom_range(0, 4) == 0) begin
        push_byte(ChZero);
        push_byte(ChLowX);
        push_crlf();
      end else begin
        add_size_line(32'd0);
      end
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, 6)) push_byte(printable());
        push_crlf();
      end
      push_crlf();
      if (style < 35) begin
        // connection drops somewhere inside the body
        cut = $urandom_range(first + 1, stim_q.size() - 1);
        while (stim_q.size() > cut) void'(stim_q.pop_back());
        push_item(CmdClose, 8'($urandom));
      end else if (style < 42) begin
        // trailing noise of any command
        repeat ($urandom_range(3, 10)) push_item(2'($urandom), 8'($urandom));
      end
    end
  endfunction

  // drive one item and wait for it to be taken
  task automatic send_item(input stim_item_t it);
    in_if.valid     <= 1'b1;
    in_if.command   <= it.cmd;
    in_if.data_byte <= it.data;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_accepted(it.cmd, it.data);
    @(negedge clk_i);
  endtask

  // sender and end of run
  initial begin
    int unsigned burst;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = CmdByte;
    in_if.data_byte = 8'h00;
    board = new();

    // directed: prefix, payload extremes, completion, ignored items, errors
    push_item(CmdStart, 8'hFF);
    push_item(CmdByte, ChTab);
    push_item(CmdByte, ChZero);
    push_item(CmdByte, ChUpX);
    push_item(CmdByte, "2");
    push_item(CmdByte, ChCr);
    push_item(CmdByte, ChLf);
    push_item(CmdByte, 8'h00);
    push_item(CmdByte, 8'hFF);
    push_item(CmdByte, ChLf);
    push_item(CmdByte, ChZero);
    push_item(CmdByte, ChLf);
    push_item(CmdByte, ChLf);
    push_item(CmdByte, "A");
    push_item(CmdClose, 8'h55);
    push_item(CmdStart, 8'hAA);
    push_item(CmdByte, ChPlus);
    push_item(CmdByte, ChLf);
    push_item(CmdClose, 8'h00);
    push_item(CmdIgnored, 8'hFF);
    push_item(CmdStart, 8'h0F);
    push_item(CmdClose, 8'hF0);

    while (stim_q.size() < ItemTarget) add_random_body();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bursts of items with random gaps
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      while (burst != 0 && stim_q.size() != 0) begin
        send_item(stim_q.pop_front());
        burst--;
      end
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: stall patterns plus one long hold-off
  initial begin
    int unsigned span;
    int unsigned rx_cycles;
    bit          held;
    out_if.ready = 1'b0;
    rx_cycles = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && rx_cycles >= HoldStart) begin
        held = 1'b1;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_if.ready <= 1'b0;
        end
      end
      span = $urandom_range(8, 64);
      case ($urandom_range(0, 2))
        0: repeat (span) begin
          @(negedge clk_i);
          out_if.ready <= 1'b1;
        end
        1: repeat (span) begin
          @(negedge clk_i);
          out_if.ready <= 1'($urandom_range(0, 1));
        end
        default: repeat (span) begin
          @(negedge clk_i);
          out_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
      rx_cycles += span;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      board.check_result(out_if.result_kind, out_if.payload_byte, out_if.error_code);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
